FILE: hw/rtl/srv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register indexes and arithmetic helpers for the reverb block.
package srv_pkg;

    // History rings are a power of two deep; positions wrap by truncation.
    localparam int HIST_AW        = 12;
    localparam int HISTORY_DEPTH  = 2 ** HIST_AW;
    localparam int COMB_TAPS      = 4;
    localparam int ALLPASS_STAGES = 4;

    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 10;
    localparam int AUDIO_W    = 16;
    localparam int PROD_W     = GAIN_W + 1 + SAMPLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COMB_IN_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMB_FB_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AP_IN_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AP_FB_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY        = 3'd4;

    localparam logic [GAIN_W-1:0]  RST_COMB_IN_GAIN = 16'd16384;
    localparam logic [GAIN_W-1:0]  RST_COMB_FB_GAIN = 16'd8192;
    localparam logic [GAIN_W-1:0]  RST_AP_IN_GAIN   = 16'd11469;
    localparam logic [GAIN_W-1:0]  RST_AP_FB_GAIN   = 16'd11469;
    localparam logic [DELAY_W-1:0] RST_DELAY        = 10'd441;

    // 1.0 in Q2.14 on the widened gain bus: rounding g*x by it returns x exactly
    localparam logic signed [GAIN_W:0] GAIN_ONE = 17'sd16384;

    localparam logic signed [SAMPLE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [AUDIO_W-1:0]  S16_MAX = 16'sh7FFF;
    localparam logic signed [AUDIO_W-1:0]  S16_MIN = 16'sh8000;

    function automatic logic signed [SAMPLE_W-1:0] sat_add32(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] s;
        s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
        if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
            return s[SAMPLE_W] ? S32_MIN : S32_MAX;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    // Q2.14 product rounded half up (floor of (p + 8192) / 16384), saturated
    function automatic logic signed [SAMPLE_W-1:0] round_q14(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] v;
        logic signed [PROD_W-15:0] q;
        v = p + PROD_W'(8192);
        q = v[PROD_W-1:14];
        if (q[PROD_W-15:SAMPLE_W-1] != {(PROD_W-13-SAMPLE_W){q[PROD_W-15]}}) begin
            return q[PROD_W-15] ? S32_MIN : S32_MAX;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [AUDIO_W-1:0] sat16(
        input logic signed [SAMPLE_W-1:0] a
    );
        if (a[SAMPLE_W-1:AUDIO_W-1] != {(SAMPLE_W-AUDIO_W+1){a[SAMPLE_W-1]}}) begin
            return a[SAMPLE_W-1] ? S16_MIN : S16_MAX;
        end
        return a[AUDIO_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/schroeder_reverb_stream.sv
`timescale 1ns / 1ps
// Schroeder reverb: comb stage plus series all-pass stages over history memories.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata[15:0] sample_in
//  m_       | out       | m_tvalid/m_tready  | m_tdata[15:0] wet_sample
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wdata[15:0]
//
// An item runs through the read, comb, all-pass and output states in turn. The single
// read/write port of each history memory and the one shared multiply-accumulate
// unit set that schedule; each all-pass stage runs its sub-steps on the MAC.
// After reset the memories are zeroed in a sweep over ALLPASS_STAGES * HISTORY_DEPTH
// addresses (16384 with the defaults); s_tready stays low during that sweep.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only stalls at its own end if the result is still not taken.
module schroeder_reverb_stream (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] wet_sample
    input  logic                              cfg_wr_en,
    input  logic [srv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW     = srv_pkg::HIST_AW;
    localparam int DEPTH  = srv_pkg::HISTORY_DEPTH;
    localparam int TAPS   = srv_pkg::COMB_TAPS;
    localparam int STAGES = srv_pkg::ALLPASS_STAGES;
    localparam int SW     = srv_pkg::SAMPLE_W;
    localparam int GW     = srv_pkg::GAIN_W;
    localparam int DW     = srv_pkg::DELAY_W;
    localparam int PW     = srv_pkg::PROD_W;
    localparam int NRD    = (TAPS > STAGES) ? TAPS : STAGES;
    localparam int CNT_W  = $clog2(NRD + 2);
    localparam int STG_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int AP_AW  = STG_W + AW;
    localparam int AP_N   = STAGES * DEPTH;
    localparam int OFF_W  = DW + $clog2(NRD + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COMB  = 3'd3;
    localparam logic [2:0] ST_AP    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [2:0] SUB_LAST = 3'd4;

    // configuration
    logic [GW-1:0] comb_in_gain_reg, comb_fb_gain_reg, ap_in_gain_reg, ap_fb_gain_reg;
    logic [DW-1:0] delay_reg;

    // control
    logic [2:0]       state_reg;
    logic [AP_AW-1:0] clr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OFF_W-1:0] off_reg;
    logic [STG_W-1:0] stage_reg;
    logic [2:0]       sub_reg;
    logic [AW-1:0]    head_reg;
    logic             crd_vld_reg, crd_first_reg, ard_vld_reg;
    logic             pv_reg, pf_reg;
    logic             m_valid_reg;

    // datapath
    logic signed [SW-1:0] comb_rdata_reg, ap_rdata_reg;
    logic signed [SW-1:0] tap1_reg, u_reg, p_reg, acc_reg, total_reg;
    logic signed [SW-1:0] ap_sh_reg [STAGES];
    logic signed [PW-1:0] prod_reg;
    logic [15:0]          m_data_reg;

    logic signed [SW-1:0] comb_mem [DEPTH];
    logic signed [SW-1:0] ap_mem   [AP_N];

    logic [AW-1:0]        d_mod;
    logic                 d_zero;
    logic [AW-1:0]        dix;
    logic                 accept;
    logic                 out_load;
    logic                 comb_re, comb_we, ap_re, ap_we;
    logic [AW-1:0]        comb_addr;
    logic [AP_AW-1:0]     ap_addr;
    logic signed [SW-1:0] comb_wdata, ap_wdata;
    logic                 mul_go, mul_first;
    logic signed [GW:0]   mul_gain;
    logic signed [SW-1:0] mul_data;
    logic signed [GW:0]   neg_ap_in_gain;
    logic signed [SW-1:0] x_ext;

    assign d_mod          = AW'(delay_reg);
    assign d_zero         = (d_mod == '0);
    assign dix            = head_reg - d_mod;
    assign accept         = s_tvalid && s_tready;
    assign out_load       = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign s_tready       = (state_reg == ST_IDLE);
    assign m_tvalid       = m_valid_reg;
    assign m_tdata        = m_data_reg;
    assign neg_ap_in_gain = -$signed({ap_in_gain_reg[GW-1], ap_in_gain_reg});
    assign x_ext          = SW'($signed(s_tdata));

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comb_in_gain_reg <= srv_pkg::RST_COMB_IN_GAIN;
            comb_fb_gain_reg <= srv_pkg::RST_COMB_FB_GAIN;
            ap_in_gain_reg   <= srv_pkg::RST_AP_IN_GAIN;
            ap_fb_gain_reg   <= srv_pkg::RST_AP_FB_GAIN;
            delay_reg        <= srv_pkg::RST_DELAY;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                srv_pkg::REG_COMB_IN_GAIN: comb_in_gain_reg <= cfg_wdata[GW-1:0];
                srv_pkg::REG_COMB_FB_GAIN: comb_fb_gain_reg <= cfg_wdata[GW-1:0];
                srv_pkg::REG_AP_IN_GAIN:   ap_in_gain_reg   <= cfg_wdata[GW-1:0];
                srv_pkg::REG_AP_FB_GAIN:   ap_fb_gain_reg   <= cfg_wdata[GW-1:0];
                srv_pkg::REG_DELAY:        delay_reg        <= cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- memory port control ----------------
    always_comb begin
        comb_re    = 1'b0;
        comb_we    = 1'b0;
        comb_addr  = head_reg;
        comb_wdata = acc_reg;
        ap_re      = 1'b0;
        ap_we      = 1'b0;
        ap_addr    = {stage_reg, head_reg};
        ap_wdata   = acc_reg;
        case (state_reg)
            ST_CLEAR: begin
                comb_we    = 1'b1;
                comb_addr  = clr_reg[AW-1:0];
                comb_wdata = '0;
                ap_we      = 1'b1;
                ap_addr    = clr_reg;
                ap_wdata   = '0;
            end
            ST_READ: begin
                // tap t lies (t+1)*delay back; off_reg holds that distance
                comb_re   = (cnt_reg < CNT_W'(TAPS));
                comb_addr = head_reg - off_reg[AW-1:0];
                ap_re     = (cnt_reg < CNT_W'(STAGES));
                ap_addr   = {cnt_reg[STG_W-1:0], dix};
            end
            ST_COMB: begin
                comb_we = 1'b1;
            end
            ST_AP: begin
                ap_we = (sub_reg == SUB_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (comb_we) begin
            comb_mem[comb_addr] <= comb_wdata;
        end
        if (comb_re) begin
            comb_rdata_reg <= comb_mem[comb_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ap_we) begin
            ap_mem[ap_addr] <= ap_wdata;
        end
        if (ap_re) begin
            ap_rdata_reg <= ap_mem[ap_addr];
        end
    end

    // ---------------- MAC issue ----------------
    always_comb begin
        mul_go    = 1'b0;
        mul_first = 1'b0;
        mul_gain  = srv_pkg::GAIN_ONE;
        mul_data  = p_reg;
        case (state_reg)
            ST_IDLE: begin
                mul_go    = accept;
                mul_first = 1'b1;
                mul_gain  = $signed({comb_in_gain_reg[GW-1], comb_in_gain_reg});
                mul_data  = x_ext;
            end
            ST_READ: begin
                mul_go   = crd_vld_reg;
                mul_gain = $signed({comb_fb_gain_reg[GW-1], comb_fb_gain_reg});
                mul_data = comb_rdata_reg;
            end
            ST_AP: begin
                case (sub_reg)
                    3'd0: begin
                        mul_go    = 1'b1;
                        mul_first = 1'b1;
                        mul_gain  = neg_ap_in_gain;
                        mul_data  = u_reg;
                    end
                    3'd1: begin
                        // adding the delayed input: exact through a gain of 1.0
                        mul_go   = 1'b1;
                        mul_gain = srv_pkg::GAIN_ONE;
                        mul_data = p_reg;
                    end
                    3'd2: begin
                        mul_go   = 1'b1;
                        mul_gain = $signed({ap_fb_gain_reg[GW-1], ap_fb_gain_reg});
                        mul_data = ap_sh_reg[0];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_gain * mul_data;
        if (pv_reg) begin
            acc_reg <= srv_pkg::sat_add32(pf_reg ? '0 : acc_reg, srv_pkg::round_q14(prod_reg));
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            off_reg       <= '0;
            stage_reg     <= '0;
            sub_reg       <= '0;
            head_reg      <= '0;
            crd_vld_reg   <= 1'b0;
            crd_first_reg <= 1'b0;
            ard_vld_reg   <= 1'b0;
            pv_reg        <= 1'b0;
            pf_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pv_reg        <= mul_go;
            pf_reg        <= mul_first;
            crd_vld_reg   <= comb_re;
            crd_first_reg <= (cnt_reg == '0);
            ard_vld_reg   <= ap_re;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AP_AW'(AP_N - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg   <= '0;
                        off_reg   <= OFF_W'(delay_reg);
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    off_reg <= off_reg + OFF_W'(delay_reg);
                    if (cnt_reg == CNT_W'(NRD + 1)) begin
                        state_reg <= ST_COMB;
                    end
                end
                ST_COMB: begin
                    stage_reg <= '0;
                    sub_reg   <= '0;
                    state_reg <= ST_AP;
                end
                ST_AP: begin
                    if (sub_reg == SUB_LAST) begin
                        sub_reg <= '0;
                        if (stage_reg == STG_W'(STAGES - 1)) begin
                            head_reg  <= head_reg + 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            stage_reg <= stage_reg + 1'b1;
                        end
                    end else begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- operand registers ----------------
    always_ff @(posedge aclk) begin
        if (crd_vld_reg && crd_first_reg) begin
            tap1_reg <= comb_rdata_reg;
        end
        // all-pass delayed outputs queue up in stage order and are consumed per stage
        if (ard_vld_reg || (state_reg == ST_AP && sub_reg == SUB_LAST)) begin
            for (int i = 0; i < STAGES - 1; i++) begin
                ap_sh_reg[i] <= ap_sh_reg[i+1];
            end
            ap_sh_reg[STAGES-1] <= ap_rdata_reg;
        end
        if (state_reg == ST_COMB) begin
            total_reg <= acc_reg;
            u_reg     <= acc_reg;
            // zero delay reads the comb value just written
            p_reg     <= d_zero ? acc_reg : tap1_reg;
        end else if (state_reg == ST_AP && sub_reg == SUB_LAST) begin
            total_reg <= srv_pkg::sat_add32(total_reg, acc_reg);
            u_reg     <= acc_reg;
            p_reg     <= d_zero ? acc_reg : ap_sh_reg[0];
        end
        if (out_load) begin
            m_data_reg <= srv_pkg::sat16(total_reg);
        end
    end

    // ---------------- assertions ----------------
    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_READ))
        else $error("accepted item did not start the read phase");

    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (!comb_we && !ap_we))
        else $error("history write during read phase");

    a_head_moves_after_ap: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg != $past(head_reg)) |-> ($past(state_reg) == ST_AP))
        else $error("write head moved outside the last all-pass step");

    a_result_presented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("finished item not presented on output");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!mul_go || mul_first) && !pv_reg)
        else $error("input ready while the MAC is busy");

endmodule

FILE: tb/schroeder_reverb_stream_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming Schroeder reverb: sample predictor plus scoreboard.
module schroeder_reverb_stream_test;
    import srv_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;   // covers the memory clearing sweep after reset
    localparam int TARGET_ITEMS   = 1700;
    localparam int LONG_HOLD      = 500;

    // Tracks the block's history rings and gains, and queues the sample each item should give.
    class reverb_scoreboard;
        int                    comb_ring[HISTORY_DEPTH];
        int                    ap_ring[ALLPASS_STAGES][HISTORY_DEPTH];
        int unsigned           head;
        logic signed [15:0]    comb_in_gain;
        logic signed [15:0]    comb_fb_gain;
        logic signed [15:0]    ap_in_gain;
        logic signed [15:0]    ap_fb_gain;
        logic [DELAY_W-1:0]    delay;
        logic signed [15:0]    expected_samples[$];
        int                    mismatches;
        int                    checked;

        function new();
            head         = 0;
            comb_in_gain = RST_COMB_IN_GAIN;
            comb_fb_gain = RST_COMB_FB_GAIN;
            ap_in_gain   = RST_AP_IN_GAIN;
            ap_fb_gain   = RST_AP_FB_GAIN;
            delay        = RST_DELAY;
            mismatches   = 0;
            checked      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_COMB_IN_GAIN: comb_in_gain = val;
                REG_COMB_FB_GAIN: comb_fb_gain = val;
                REG_AP_IN_GAIN:   ap_in_gain   = val;
                REG_AP_FB_GAIN:   ap_fb_gain   = val;
                REG_DELAY:        delay        = val[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return int'(v);
        endfunction

        // Q2.14 gain times sample, rounded half up; >>> on a longint is a floor division
        function int scaled(int g, int x);
            longint p;
            p = longint'(g) * longint'(x) + 64'sd8192;
            return sat32(p >>> 14);
        endfunction

        function int unsigned behind(int unsigned off);
            return (head + HISTORY_DEPTH - (off % HISTORY_DEPTH)) % HISTORY_DEPTH;
        endfunction

        function void note_sample(logic [15:0] raw);
            int          x;
            int          acc;
            int          total;
            int          y;
            int          cur;
            int          old;
            int          neg_ap_in;
            int unsigned d;
            int unsigned back_pos;
            x = int'($signed(raw));
            d = delay;
            acc = scaled(comb_in_gain, x);
            for (int i = 0; i < COMB_TAPS; i++) begin
                acc = sat32(longint'(acc) + scaled(comb_fb_gain, comb_ring[behind((i + 1) * d)]));
            end
            comb_ring[head] = acc;
            total = acc;
            back_pos = behind(d);
            neg_ap_in = ap_in_gain;
            neg_ap_in = -neg_ap_in;
            // each stage reads its input ring after that ring got this item's value
            for (int s = 0; s < ALLPASS_STAGES; s++) begin
                cur = (s == 0) ? comb_ring[head] : ap_ring[s-1][head];
                old = (s == 0) ? comb_ring[back_pos] : ap_ring[s-1][back_pos];
                y = sat32(longint'(scaled(neg_ap_in, cur)) + old);
                y = sat32(longint'(y) + scaled(ap_fb_gain, ap_ring[s][back_pos]));
                ap_ring[s][head] = y;
                total = sat32(longint'(total) + y);
            end
            head = (head + 1) % HISTORY_DEPTH;
            if (total > 32767) total = 32767;
            if (total < -32768) total = -32768;
            expected_samples.push_back(total[15:0]);
        endfunction

        function void check_sample(logic [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0) begin
                $error("wet_sample: result with nothing expected, got %0d", $signed(got));
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                checked++;
                if (want !== got) begin
                    $error("wet_sample: expected %0d, got %0d", want, $signed(got));
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    reverb_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int items_in;
    int settings_used;

    schroeder_reverb_stream u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Sample both channels on the rising edge, before the block's own updates land
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_sample(s_tdata);
            items_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_sample(m_tdata);
        end
    end

    // Output backpressure; a long hold-off is counted down here
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_sample(input logic [15:0] x);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_samples.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] cig, input logic [15:0] cfb,
                                  input logic [15:0] aig, input logic [15:0] afb,
                                  input logic [15:0] dly);
        drive_reg(REG_COMB_IN_GAIN, cig);
        drive_reg(REG_COMB_FB_GAIN, cfb);
        drive_reg(REG_AP_IN_GAIN, aig);
        drive_reg(REG_AP_FB_GAIN, afb);
        drive_reg(REG_DELAY, dly);
        // indexes past the last register must leave everything alone
        drive_reg(REG_DELAY + CFG_IDX_W'($urandom_range(1, 3)), 16'($urandom));
        settings_used++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            1, 2: return 16'($signed($urandom_range(0, 511)) - 256);
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // half the time a gain below 1.0 in magnitude so that tails do not just saturate
    function automatic logic [15:0] pick_gain();
        if ($urandom_range(1)) return 16'($signed($urandom_range(0, 16383)) - 8192);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_delay();
        logic [15:0] v;
        v = 16'($urandom);   // upper bits are junk the block must drop
        if ($urandom_range(3) == 0) v[DELAY_W-1:0] = DELAY_W'($urandom_range(0, 1023));
        else v[DELAY_W-1:0] = DELAY_W'($urandom_range(1, 24));
        return v;
    endfunction

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                             input int hold_at);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_left = LONG_HOLD;
            send_sample(pick_sample());
        end
    endtask

    initial begin
        logic [15:0] directed[$];
        int          mode;
        sb                 = new();
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          = 0;
        items_in           = 0;
        settings_used      = 1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset gains: full-scale steps, sign flips and alternating bit patterns
        directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h7FFF,
                     16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h4000, 16'hC000, 16'h0000,
                     16'h0000, 16'h7FFE, 16'h8001, 16'h00FF, 16'hFF00, 16'h0000};
        foreach (directed[i]) send_sample(directed[i]);
        wait_drained();

        // short delay, echoes come back fast; long output hold-off fills the block
        apply_settings(16'sd16384, -16'sd8192, 16'sd11469, 16'sd8000, 16'd3);
        run_phase(250, 0, 0, 40);
        wait_drained();   // sender pause with nothing in flight, same settings
        run_phase(100, 0, 0, -1);
        wait_drained();

        // most positive gains with the most negative all-pass input gain, delay of one
        apply_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1);
        run_phase(200, 74, 0, -1);
        wait_drained();

        // most negative gains but the most positive all-pass input gain, longest delay
        apply_settings(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'd1023);
        run_phase(200, 0, 74, -1);
        wait_drained();

        // delay truncates to zero: each stage sees the write position itself
        apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), 16'hFC00);
        run_phase(150, 37, 37, -1);
        wait_drained();

        apply_settings(16'sd8192, 16'sd4096, -16'sd6000, 16'sd6000, 16'd0);
        run_phase(150, 0, 0, 60);
        wait_drained();

        mode = 0;
        while (items_in < TARGET_ITEMS) begin
            apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_delay());
            case (mode % 4)
                0: run_phase($urandom_range(80, 140), 0, 0, -1);
                1: run_phase($urandom_range(80, 140), 74, 0, -1);
                2: run_phase($urandom_range(80, 140), 0, 74, -1);
                default: run_phase($urandom_range(80, 140), 37, 37, -1);
            endcase
            wait_drained();
            mode++;
        end

        repeat (40) @(posedge aclk);
        if (sb.expected_samples.size() != 0) begin
            $error("wet_sample: %0d results never arrived", sb.expected_samples.size());
            sb.mismatches++;
        end
        $display("covered %0d samples, %0d results checked, over %0d register settings",
                 items_in, sb.checked, settings_used);
        $display("incl. zero, unit and longest delays, extreme gains and long output stalls");
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
